FILE: sv/sync_framed_ack_receiver_crc16_defines.svh
// assertion macros shared by the receiver modules
`ifndef SYNC_FRAMED_ACK_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAMED_ACK_RECEIVER_CRC16_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SFA_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// implication checked at the next clock edge
`define SFA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: sv/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// types, constants and the crc function of the acknowledgement receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfa_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 2048;
   localparam int unsigned COUNT_WIDTH      = 17;
   localparam logic [31:0] SYNC_WORD        = 32'h109BC4F0;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [15:0] CRC_POLY         = 16'hA001;
   localparam logic [COUNT_WIDTH-1:0] HEADER_BYTES = COUNT_WIDTH'(16);
   localparam logic [COUNT_WIDTH-1:0] CRC_START    = COUNT_WIDTH'(8);
   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT    = COUNT_WIDTH'(MAX_PACKET_BYTES);
   localparam int unsigned QUEUE_DEPTH      = 4;
   localparam int unsigned QUEUE_AW         = 2;

   localparam logic [1:0] KIND_ARM  = 2'd0;
   localparam logic [1:0] KIND_BYTE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FAIL   = 2'd1;
   localparam logic [1:0] ST_CRC    = 2'd2;
   localparam logic [1:0] ST_DEVICE = 2'd3;

   // one result item
   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [1:0]  status;
      logic [7:0]  device_code;
      logic [15:0] data_length;
      logic [7:0]  sequence_res;
      logic [7:0]  category;
      logic [7:0]  command;
   } result_type;

   // work from front to back: up to two result items of one step
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: sv/sfa_front.sv
// ----------------------------------------------------------------------------
// sfa_front
// sync hunt, header capture, crc, timeout and overflow; builds result entries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_framed_ack_receiver_crc16_defines.svh"

module sfa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [1:0]          in_kind,
   input  logic [7:0]          in_byte,
   input  logic [31:0]         in_ticks,
   output logic                ent_valid,
   output sfa_pkg::entry_type  ent_data
);

   logic        armed_ff, armed_in;
   logic [23:0] window_ff, window_in;
   logic [sfa_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [15:0] crc_ff, crc_in;
   logic [31:0] ids_ff, ids_in;
   logic [31:0] remain_ff, remain_in;

   logic [sfa_pkg::COUNT_WIDTH-1:0] n;
   logic [31:0] word;
   logic [15:0] crc_next;
   sfa_pkg::result_type fail_r, pay_r, fin_r;

   always_comb begin
      armed_in  = armed_ff;
      window_in = window_ff;
      count_in  = count_ff;
      length_in = length_ff;
      rcrc_in   = rcrc_ff;
      crc_in    = crc_ff;
      ids_in    = ids_ff;
      remain_in = remain_ff;
      ent_valid = 1'b0;
      ent_data  = '0;
      n         = count_ff + sfa_pkg::COUNT_WIDTH'(1);
      word      = {in_byte, window_ff};
      crc_next  = sfa_pkg::crc_byte(crc_ff, in_byte);

      fail_r = '0;
      fail_r.result_kind = 1'b1;
      fail_r.status      = sfa_pkg::ST_FAIL;
      pay_r = '0;
      pay_r.payload_byte  = in_byte;
      pay_r.payload_index = 16'(count_ff - sfa_pkg::HEADER_BYTES);
      fin_r = '0;
      fin_r.result_kind = 1'b1;

      if (in_valid) begin
         if (in_kind == sfa_pkg::KIND_ARM) begin
            armed_in  = 1'b1;
            window_in = '0;
            count_in  = '0;
            length_in = '0;
            rcrc_in   = '0;
            crc_in    = sfa_pkg::CRC_INIT;
            ids_in    = '0;
            remain_in = in_ticks;
         end else if (armed_ff && in_kind == sfa_pkg::KIND_TICK) begin
            if (remain_ff == 32'd0) begin
               armed_in       = 1'b0;
               ent_valid      = 1'b1;
               ent_data.first = fail_r;
            end else begin
               remain_in = remain_ff - 32'd1;
            end
         end else if (armed_ff && in_kind == sfa_pkg::KIND_BYTE) begin
            if (count_ff < sfa_pkg::COUNT_WIDTH'(3)) begin
               window_in = window_ff | (24'(in_byte) << (count_ff[1:0] * 5'd8));
               count_in  = n;
            end else if (count_ff == sfa_pkg::COUNT_WIDTH'(3)) begin
               if (word == sfa_pkg::SYNC_WORD) count_in = sfa_pkg::COUNT_WIDTH'(4);
               else window_in = word[31:8];
            end else if (n > sfa_pkg::MAX_COUNT) begin
               armed_in       = 1'b0;
               ent_valid      = 1'b1;
               ent_data.first = fail_r;
            end else begin
               count_in = n;
               case (count_ff)
                  sfa_pkg::COUNT_WIDTH'(4):  length_in = {8'h00, in_byte};
                  sfa_pkg::COUNT_WIDTH'(5):  length_in = {in_byte, length_ff[7:0]};
                  sfa_pkg::COUNT_WIDTH'(6):  rcrc_in   = {8'h00, in_byte};
                  sfa_pkg::COUNT_WIDTH'(7):  rcrc_in   = {in_byte, rcrc_ff[7:0]};
                  sfa_pkg::COUNT_WIDTH'(8):  ids_in[7:0]   = in_byte;
                  sfa_pkg::COUNT_WIDTH'(9):  ids_in[15:8]  = in_byte;
                  sfa_pkg::COUNT_WIDTH'(10): ids_in[23:16] = in_byte;
                  sfa_pkg::COUNT_WIDTH'(11): ids_in[31:24] = in_byte;
                  default: ;
               endcase
               if (count_ff >= sfa_pkg::CRC_START) crc_in = crc_next;
               fin_r.data_length  = length_in;
               fin_r.sequence_res = ids_in[7:0];
               fin_r.category     = ids_in[15:8];
               fin_r.command      = ids_in[23:16];
               if (crc_in != rcrc_in) begin
                  fin_r.status = sfa_pkg::ST_CRC;
               end else if (ids_in[31:24] != 8'h00) begin
                  fin_r.status      = sfa_pkg::ST_DEVICE;
                  fin_r.device_code = ids_in[31:24];
               end else begin
                  fin_r.status = sfa_pkg::ST_OK;
               end
               if (n >= sfa_pkg::HEADER_BYTES &&
                   n >= ({1'b0, length_in} + sfa_pkg::HEADER_BYTES)) begin
                  armed_in  = 1'b0;
                  ent_valid = 1'b1;
                  if (count_ff >= sfa_pkg::HEADER_BYTES) begin
                     ent_data.two    = 1'b1;
                     ent_data.first  = pay_r;
                     ent_data.second = fin_r;
                  end else begin
                     ent_data.first = fin_r;
                  end
               end else if (count_ff >= sfa_pkg::HEADER_BYTES) begin
                  ent_valid      = 1'b1;
                  ent_data.first = pay_r;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         window_ff <= '0;
         count_ff  <= '0;
         length_ff <= '0;
         rcrc_ff   <= '0;
         crc_ff    <= sfa_pkg::CRC_INIT;
         ids_ff    <= '0;
         remain_ff <= '0;
      end else begin
         armed_ff  <= armed_in;
         window_ff <= window_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         rcrc_ff   <= rcrc_in;
         crc_ff    <= crc_in;
         ids_ff    <= ids_in;
         remain_ff <= remain_in;
      end
   end

   `SFA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= sfa_pkg::MAX_COUNT, "packet byte count beyond limit")
   `SFA_ASSERT_IMPL(a_no_out_idle, clock, reset, !armed_ff && in_kind != sfa_pkg::KIND_ARM,
      !ent_valid, "item produced while disarmed")
   `SFA_ASSERT_NEXT(a_disarm_final, clock, reset, ent_valid && ent_data.first.result_kind,
      !armed_ff, "still armed after final status")

endmodule

FILE: sv/sfa_back.sv
// ----------------------------------------------------------------------------
// sfa_back
// entry queue and output stage; drains one or two result items per entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_framed_ack_receiver_crc16_defines.svh"

module sfa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                ent_valid,
   input  sfa_pkg::entry_type  ent_data,
   output logic                full,
   output logic                empty,
   input  logic                pop,
   output sfa_pkg::result_type rsp
);

   sfa_pkg::entry_type q_ff [sfa_pkg::QUEUE_DEPTH];
   logic [sfa_pkg::QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [sfa_pkg::QUEUE_AW:0]   used_ff, used_in;
   logic                         half_ff, half_in;
   logic                         take;
   logic                         done;

   assign full  = used_ff >= (sfa_pkg::QUEUE_AW+1)'(sfa_pkg::QUEUE_DEPTH - 1);
   assign empty = used_ff == '0;
   assign rsp   = half_ff ? q_ff[rd_ff].second : q_ff[rd_ff].first;
   assign take  = pop && !empty;
   assign done  = take && (half_ff || !q_ff[rd_ff].two);

   always_comb begin
      wr_in   = ent_valid ? wr_ff + 1'b1 : wr_ff;
      rd_in   = done ? rd_ff + 1'b1 : rd_ff;
      half_in = take ? !done : half_ff;
      used_in = used_ff + (sfa_pkg::QUEUE_AW+1)'(ent_valid)
                - (sfa_pkg::QUEUE_AW+1)'(done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         used_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         used_ff <= used_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_valid) q_ff[wr_ff] <= ent_data;
   end

   `SFA_ASSERT_IMPL(a_no_overrun, clock, reset, ent_valid,
      used_ff < (sfa_pkg::QUEUE_AW+1)'(sfa_pkg::QUEUE_DEPTH), "entry queue overrun")
   `SFA_ASSERT_IMPL(a_half_valid, clock, reset, half_ff,
      !empty && q_ff[rd_ff].two, "second half without a paired entry")

endmodule

FILE: sv/sync_framed_ack_receiver_crc16.sv
// ----------------------------------------------------------------------------
// sync_framed_ack_receiver_crc16
// acknowledgement packet receiver with sync hunt and crc-16/modbus check
// ----------------------------------------------------------------------------
// channel   direction  handshake       payload
// req_      in         push / full     kind, rx_byte, timeout_ticks
// rsp_      out        pop / empty     result item, nine fields
//
// one item per cycle while full is low; the front updates state in the cycle of acceptance
// a result item is written to the queue at the clock edge that accepts its input item
// full rises when the four-entry queue holds three entries; no clearing pass
// synchronous active-high reset disarms and empties the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_framed_ack_receiver_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_timeout_ticks,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_device_code,
   output logic [15:0] rsp_data_length,
   output logic [7:0]  rsp_sequence_res,
   output logic [7:0]  rsp_category,
   output logic [7:0]  rsp_command
);

   logic                ent_valid;
   sfa_pkg::entry_type  ent_data;
   sfa_pkg::result_type rsp;

   sfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push && !full),
      .in_kind   (req_kind),
      .in_byte   (req_rx_byte),
      .in_ticks  (req_timeout_ticks),
      .ent_valid (ent_valid),
      .ent_data  (ent_data)
   );

   sfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ent_valid (ent_valid),
      .ent_data  (ent_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_result_kind   = rsp.result_kind;
   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_status        = rsp.status;
   assign rsp_device_code   = rsp.device_code;
   assign rsp_data_length   = rsp.data_length;
   assign rsp_sequence_res  = rsp.sequence_res;
   assign rsp_category      = rsp.category;
   assign rsp_command       = rsp.command;

endmodule

FILE: tb/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker
// watches the receiver's channels, predicts each result item, compares them
// ----------------------------------------------------------------------------
// accepted request items run through a cycle-free model of the receiver:
// sync hunt, header capture, crc-16/modbus, timeout and overflow. the
// expected items wait in order and each accepted result item is compared
// with the oldest one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_timeout_ticks,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_result_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [15:0] rsp_payload_index,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_device_code,
   input  logic [15:0] rsp_data_length,
   input  logic [7:0]  rsp_sequence_res,
   input  logic [7:0]  rsp_category,
   input  logic [7:0]  rsp_command,
   output int          errors,
   output int          pending,
   output int          finals_seen,
   output int          payloads_seen
);

   sfa_pkg::result_type expected_items[$];

   logic        rx_armed;
   logic [23:0] hunt_window;
   logic [16:0] frame_count;
   logic [15:0] frame_length;
   logic [15:0] frame_crc;
   logic [15:0] calc_crc;
   logic [31:0] frame_ids;
   logic [31:0] ticks_left;

   function automatic logic [15:0] modbus_update(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   task automatic clear_frame();
      hunt_window  = '0;
      frame_count  = '0;
      frame_length = '0;
      frame_crc    = '0;
      calc_crc     = sfa_pkg::CRC_INIT;
      frame_ids    = '0;
   endtask

   task automatic receive_item(logic [1:0] kind, logic [7:0] b, logic [31:0] budget);
      sfa_pkg::result_type r;
      logic [31:0] word;
      logic [16:0] p;
      if (kind == sfa_pkg::KIND_ARM) begin
         clear_frame();
         rx_armed   = 1'b1;
         ticks_left = budget;
         return;
      end
      if (!rx_armed || kind == 2'd3) return;
      if (kind == sfa_pkg::KIND_TICK) begin
         if (ticks_left == 0) begin
            rx_armed = 1'b0;
            r = '0;
            r.result_kind = 1'b1;
            r.status = sfa_pkg::ST_FAIL;
            expected_items.push_back(r);
         end else begin
            ticks_left--;
         end
         return;
      end
      if (frame_count < 3) begin
         hunt_window = hunt_window | (24'(b) << (8 * frame_count));
         frame_count++;
         return;
      end
      if (frame_count == 3) begin
         word = {b, hunt_window};
         if (word == sfa_pkg::SYNC_WORD) frame_count = 4;
         else hunt_window = word[31:8];
         return;
      end
      p = frame_count;
      if (p + 1 > sfa_pkg::MAX_PACKET_BYTES) begin
         rx_armed = 1'b0;
         r = '0;
         r.result_kind = 1'b1;
         r.status = sfa_pkg::ST_FAIL;
         expected_items.push_back(r);
         return;
      end
      frame_count = p + 1;
      case (p)
         4: frame_length[7:0] = b;
         5: frame_length[15:8] = b;
         6: frame_crc[7:0] = b;
         7: frame_crc[15:8] = b;
         8: frame_ids[7:0] = b;
         9: frame_ids[15:8] = b;
         10: frame_ids[23:16] = b;
         11: frame_ids[31:24] = b;
         default: ;
      endcase
      if (p >= sfa_pkg::CRC_START) calc_crc = modbus_update(calc_crc, b);
      if (p >= sfa_pkg::HEADER_BYTES) begin
         r = '0;
         r.payload_byte = b;
         r.payload_index = 16'(p - sfa_pkg::HEADER_BYTES);
         expected_items.push_back(r);
      end
      if (frame_count >= sfa_pkg::HEADER_BYTES &&
          frame_count >= 17'(frame_length) + sfa_pkg::HEADER_BYTES) begin
         r = '0;
         r.result_kind = 1'b1;
         if (calc_crc != frame_crc) r.status = sfa_pkg::ST_CRC;
         else if (frame_ids[31:24] != 0) begin
            r.status = sfa_pkg::ST_DEVICE;
            r.device_code = frame_ids[31:24];
         end else r.status = sfa_pkg::ST_OK;
         r.data_length = frame_length;
         r.sequence_res = frame_ids[7:0];
         r.category = frame_ids[15:8];
         r.command = frame_ids[23:16];
         expected_items.push_back(r);
         rx_armed = 1'b0;
      end
   endtask

   task automatic compare_item();
      sfa_pkg::result_type e;
      if (expected_items.size() == 0) begin
         $error("unexpected result item, kind %0d", rsp_result_kind);
         errors++;
         return;
      end
      e = expected_items.pop_front();
      if (rsp_result_kind) finals_seen++;
      else payloads_seen++;
      if (rsp_result_kind !== e.result_kind) begin
         $error("result_kind exp %0h got %0h", e.result_kind, rsp_result_kind); errors++;
      end
      if (rsp_payload_byte !== e.payload_byte) begin
         $error("payload_byte exp %0h got %0h", e.payload_byte, rsp_payload_byte); errors++;
      end
      if (rsp_payload_index !== e.payload_index) begin
         $error("payload_index exp %0h got %0h", e.payload_index, rsp_payload_index);
         errors++;
      end
      if (rsp_status !== e.status) begin
         $error("status exp %0h got %0h", e.status, rsp_status); errors++;
      end
      if (rsp_device_code !== e.device_code) begin
         $error("device_code exp %0h got %0h", e.device_code, rsp_device_code); errors++;
      end
      if (rsp_data_length !== e.data_length) begin
         $error("data_length exp %0h got %0h", e.data_length, rsp_data_length); errors++;
      end
      if (rsp_sequence_res !== e.sequence_res) begin
         $error("sequence_res exp %0h got %0h", e.sequence_res, rsp_sequence_res); errors++;
      end
      if (rsp_category !== e.category) begin
         $error("category exp %0h got %0h", e.category, rsp_category); errors++;
      end
      if (rsp_command !== e.command) begin
         $error("command exp %0h got %0h", e.command, rsp_command); errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      finals_seen = 0;
      payloads_seen = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rx_armed = 1'b0;
         ticks_left = '0;
         clear_frame();
         expected_items.delete();
      end else begin
         if (pop && !empty) compare_item();
         if (push && !full) receive_item(req_kind, req_rx_byte, req_timeout_ticks);
      end
      pending = expected_items.size();
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the acknowledgement packet receiver
// ----------------------------------------------------------------------------
// directed packets cover good, crc error, device error, timeout, re-arm and
// ignored items; random packets follow with random idling on both sides and
// one long result stall that fills the queue. tb_checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [1:0]  req_kind;
   logic [7:0]  req_rx_byte;
   logic [31:0] req_timeout_ticks;
   logic        empty;
   logic        pop;
   logic        rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_payload_index;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_device_code;
   logic [15:0] rsp_data_length;
   logic [7:0]  rsp_sequence_res;
   logic [7:0]  rsp_category;
   logic [7:0]  rsp_command;

   int errors, pending, finals_seen, payloads_seen;
   int items_sent;
   bit quiet_phase;
   bit hold_rsp;
   bit stall_done;
   logic [7:0] frame_bytes[$];

   sync_framed_ack_receiver_crc16 dut (.*);

   tb_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb: done, errors");
      $finish;
   end

   // result side: random stalls, one long hold-off
   initial begin
      pop = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            pop <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 1'b0;
            stall_done = 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_item(logic [1:0] kind, logic [7:0] b, logic [31:0] budget);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      push <= 1'b1;
      req_kind <= kind;
      req_rx_byte <= b;
      req_timeout_ticks <= budget;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [15:0] frame_crc(int from);
      logic [15:0] c;
      c = sfa_pkg::CRC_INIT;
      for (int i = from; i < frame_bytes.size(); i++)
         c = sfa_pkg::crc_byte(c, frame_bytes[i]);
      return c;
   endfunction

   // builds a packet; corrupt 0 good, 1 crc corrupt
   task automatic build_frame(int len, logic [7:0] dev, bit corrupt);
      logic [15:0] c;
      frame_bytes = '{8'hF0, 8'hC4, 8'h9B, 8'h10, len[7:0], len[15:8], 8'h00, 8'h00,
                      8'($urandom), 8'($urandom), 8'($urandom), dev,
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
      c = frame_crc(8);
      if (corrupt) c = c ^ 16'(1 << $urandom_range(0, 15));
      frame_bytes[6] = c[7:0];
      frame_bytes[7] = c[15:8];
   endtask

   task automatic send_frame(int noise);
      for (int i = 0; i < noise; i++) send_item(sfa_pkg::KIND_BYTE, 8'($urandom), 0);
      foreach (frame_bytes[i]) send_item(sfa_pkg::KIND_BYTE, frame_bytes[i], 0);
   endtask

   task automatic random_packet();
      int pick;
      pick = $urandom_range(0, 19);
      send_item(sfa_pkg::KIND_ARM, 0,
                $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 3)) : 32'hFFFFFFFF);
      if (pick < 12) build_frame($urandom_range(0, 12), $urandom_range(0, 1) ? 8'($urandom) : 8'h00,
                                 $urandom_range(0, 3) == 0);
      else if (pick < 15) build_frame($urandom_range(0, 12), 8'h00, 0);
      else begin
         for (int i = 0; i < $urandom_range(1, 10); i++)
            send_item(2'($urandom_range(1, 3)), 8'($urandom), 32'($urandom));
         return;
      end
      send_frame($urandom_range(0, 4));
      if (pick == 13) send_item(sfa_pkg::KIND_TICK, 0, 0);
      if (pick == 14) send_item(2'd3, 8'hFF, 32'hFFFFFFFF);
   endtask

   initial begin
      push = 1'b0;
      req_kind = sfa_pkg::KIND_ARM;
      req_rx_byte = '0;
      req_timeout_ticks = '0;
      items_sent = 0;
      quiet_phase = 1'b0;
      hold_rsp = 1'b0;
      stall_done = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ignored while disarmed, then timeout at zero budget
      send_item(sfa_pkg::KIND_BYTE, 8'hFF, 0);
      send_item(sfa_pkg::KIND_TICK, 0, 0);
      send_item(2'd3, 8'hAA, 32'hFFFFFFFF);
      send_item(sfa_pkg::KIND_ARM, 0, 0);
      send_item(sfa_pkg::KIND_TICK, 0, 0);
      // budget of two ticks, then expiry; re-arm mid-frame
      send_item(sfa_pkg::KIND_ARM, 0, 2);
      repeat (3) send_item(sfa_pkg::KIND_TICK, 0, 0);
      send_item(sfa_pkg::KIND_ARM, 0, 32'hFFFFFFFF);
      send_item(sfa_pkg::KIND_BYTE, 8'hF0, 0);
      send_item(sfa_pkg::KIND_BYTE, 8'hC4, 0);
      send_item(sfa_pkg::KIND_ARM, 0, 32'hFFFFFFFF);
      build_frame(0, 8'h00, 0);
      send_frame(0);
      send_item(sfa_pkg::KIND_ARM, 0, 32'hFFFFFFFF);
      build_frame(3, 8'hFF, 0);
      send_frame(2);
      send_item(sfa_pkg::KIND_ARM, 0, 5);
      build_frame(2, 8'h00, 1);
      send_frame(1);

      // long result stall while packets keep coming
      hold_rsp = 1'b1;
      while (items_sent < 850) begin
         if (items_sent > 780) quiet_phase = 1'b1;
         random_packet();
      end
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("tb: %0d items sent, %0d payload and %0d final result items checked",
               items_sent, payloads_seen, finals_seen);
      if (errors == 0 && stall_done) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
